### rtl/rgb_median_window_filter_top_macros.svh
// Assertion macros for the median window filter.
`ifndef RGB_MEDIAN_WINDOW_FILTER_TOP_MACROS_SVH
`define RGB_MEDIAN_WINDOW_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RMWF_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define RMWF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RMWF_ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define RMWF_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

### rtl/rmwf_pkg.sv
// Shared constants and types of the median window filter.
package rmwf_pkg;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_RADIUS = 4;
   localparam int COL_W  = 10;
   localparam int ROW_W  = 13;
   localparam int WID_W  = 11;
   localparam int HGT_W  = 13;
   localparam int LVL_W  = 4;
   localparam int RAD_W  = 3;
   localparam int BANK_SHIFT = 10;
   localparam int BANKS      = 2 * MAX_RADIUS + 1;
   localparam int LINE_DEPTH = BANKS * MAX_WIDTH;
   localparam int ADDR_W     = 14;
   localparam int LIN_W      = 22;
   localparam int PROD_W     = 25;
   localparam int RECIP9     = 7282;   // ceil(2^16 / 9)
   localparam int PIX_W      = 24;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_LEVEL  = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic             start;
      logic [11:0]      row;
      logic [COL_W-1:0] col;
      logic [WID_W-1:0] width;
   } addr_req_type;
endpackage

### rtl/rmwf_addr.sv
// Line memory address unit: (row * width + col) mod depth over three stages.
module rmwf_addr
   import rmwf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  addr_req_type      req,
   output logic              done,
   output logic [ADDR_W-1:0] addr
);
   logic              v1_ff, v2_ff, done_ff;
   logic [LIN_W-1:0]  lin_ff, lin2_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [8:0]        quot;
   logic [LIN_W-1:0]  quot_off;

   assign quot     = prod_ff[PROD_W-1:16];
   assign quot_off = (LIN_W'(quot) * LIN_W'(BANKS)) << BANK_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= req.start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
      lin_ff  <= LIN_W'(LIN_W'(req.row) * LIN_W'(req.width) + LIN_W'(req.col));
      prod_ff <= PROD_W'(lin_ff[LIN_W-1:BANK_SHIFT]) * PROD_W'(RECIP9);
      lin2_ff <= lin_ff;
      addr_ff <= ADDR_W'(lin2_ff - quot_off);
   end

   assign done = done_ff;
   assign addr = addr_ff;
endmodule

### rtl/rgb_median_window_filter_top.sv
// Top level of the per-channel RGB median window filter.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-----------------
//  request | req_cmd, req_*_in              | req_valid/ready
//  result  | rsp_*_out, rsp_frame_end       | rsp_valid/ready
//  config  | csr_index, csr_wdata           | csr_we, no wait
//
// Words are taken one at a time. A pixel word waits on the address pipe for its
// write; a drain tick skips it. A word that yields a result then runs eight
// bit-serial rank passes, each sweeping the clipped window through the single
// read port of the line memory, then the output load.
// Reset: synchronous, clears counters and handshake; the line memory is not
// cleared. A finished result waits in the output register while the next
// word is taken; a stalled result holds the engine before the next load.
module rgb_median_window_filter_top
   import rmwf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_frame_end,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   `include "rgb_median_window_filter_top_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_WADDR, S_CHK, S_MUL, S_CMP,
      S_ROWSTART, S_SWEEP, S_DRAIN, S_DECIDE, S_OUT
   } state_type;

   state_type state_ff;

   // config
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [LVL_W-1:0] level_ff;
   logic [WID_W-1:0] w_eff;
   logic [HGT_W-1:0] h_eff;
   logic [RAD_W-1:0] r_eff;

   // stream position
   logic             cmd_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [COL_W-1:0] in_col_ff, out_col_ff;
   logic [ROW_W-1:0] in_row_ff, out_row_ff;

   // window
   logic [11:0]      need_row_ff, y1_ff, y_ff;
   logic [COL_W-1:0] need_col_ff, x1_ff, x_ff;
   logic [23:0]      inpos_ff, needpos_ff;

   // rank selection, one lane per colour: 0 red, 1 green, 2 blue
   logic [5:0] rank_ff [3];
   logic [6:0] cnt_ff  [3];
   logic [7:0] pre_ff  [3];
   logic [2:0] bit_ff;
   logic [2:0] hit;
   logic [7:0] himask;

   // line memory
   logic [PIX_W-1:0]  line_mem [LINE_DEPTH];
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [PIX_W-1:0]  rd_data_ff;
   logic              rdv_ff;
   logic              mem_we, mem_re;

   addr_req_type      areq_ff;
   logic              addr_done;
   logic [ADDR_W-1:0] addr_out;

   // output register
   logic       rsp_valid_ff, fe_ff;
   logic [7:0] rsp_r_ff, rsp_g_ff, rsp_b_ff;

   // combinational helpers
   logic             prep_clr;
   logic [ROW_W-1:0] prep_row;
   logic [COL_W-1:0] prep_col;
   logic [WID_W-1:0] in_col_inc, out_col_inc;
   logic [COL_W-1:0] chk_col;
   logic [ROW_W-1:0] nr_sum;
   logic [11:0]      chk_need_row, chk_y1;
   logic [WID_W-1:0] nc_sum;
   logic [COL_W-1:0] chk_need_col, chk_x1;
   logic [3:0]       win_rows, win_cols;
   logic [6:0]       win_n;
   logic [5:0]       win_rank;
   logic [ROW_W-1:0] out_row_inc;
   logic             out_wrap;

   rmwf_addr u_addr (
      .clock (clock),
      .reset (reset),
      .req   (areq_ff),
      .done  (addr_done),
      .addr  (addr_out)
   );

   // effective settings: zero size reads as one, oversize saturates
   always_comb begin
      if (width_ff == '0)                    w_eff = WID_W'(1);
      else if (width_ff > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
      else                                   w_eff = width_ff;
      if (height_ff == '0)                     h_eff = HGT_W'(1);
      else if (height_ff > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
      else                                     h_eff = height_ff;
      if (level_ff[LVL_W-1:1] > RAD_W'(MAX_RADIUS)) r_eff = RAD_W'(MAX_RADIUS);
      else                                          r_eff = level_ff[LVL_W-1:1];
   end

   always_comb begin
      // start of word: stale frame restarts, column wraps
      prep_clr = out_row_ff >= h_eff;
      prep_row = prep_clr ? '0 : in_row_ff;
      prep_col = (prep_clr || {1'b0, in_col_ff} >= w_eff) ? '0 : in_col_ff;
      in_col_inc  = {1'b0, in_col_ff} + WID_W'(1);
      out_col_inc = {1'b0, out_col_ff} + WID_W'(1);
      out_wrap    = out_col_inc >= w_eff;
      out_row_inc = out_wrap ? out_row_ff + ROW_W'(1) : out_row_ff;

      // clipped window of the next output
      chk_col = ({1'b0, out_col_ff} >= w_eff) ? '0 : out_col_ff;
      nr_sum  = out_row_ff + ROW_W'(r_eff);
      chk_need_row = (nr_sum > h_eff - HGT_W'(1)) ? 12'(h_eff - HGT_W'(1)) : 12'(nr_sum);
      nc_sum  = {1'b0, chk_col} + WID_W'(r_eff);
      chk_need_col = (nc_sum > w_eff - WID_W'(1)) ? COL_W'(w_eff - WID_W'(1))
                                                  : COL_W'(nc_sum);
      chk_y1 = (out_row_ff > ROW_W'(r_eff)) ? 12'(out_row_ff - ROW_W'(r_eff)) : '0;
      chk_x1 = (chk_col > COL_W'(r_eff)) ? chk_col - COL_W'(r_eff) : '0;

      win_rows = 4'(need_row_ff - y1_ff) + 4'd1;
      win_cols = 4'(need_col_ff - x1_ff) + 4'd1;
      win_n    = 7'(win_rows) * 7'(win_cols);
      win_rank = 6'((win_n - 7'd1) >> 1);

      // bit-serial rank test: prefix above the current bit matches, bit is zero
      himask = 8'(8'hFE << bit_ff);
      for (int c = 0; c < 3; c++) begin
         hit[c] = (((rd_data_ff[23-8*c -: 8] ^ pre_ff[c]) & himask) == 8'h00) &&
                  !rd_data_ff[23-8*c - 7 + int'(bit_ff)];
      end
   end

   assign mem_we = (state_ff == S_WADDR) && addr_done;
   assign mem_re = (state_ff == S_SWEEP);

   always_ff @(posedge clock) begin
      if (mem_we) line_mem[addr_out] <= pix_ff;
      if (mem_re) rd_data_ff <= line_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(1024);
         height_ff <= HGT_W'(1024);
         level_ff  <= LVL_W'(8);
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata[WID_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[HGT_W-1:0];
            CSR_LEVEL:  level_ff  <= csr_wdata[LVL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         rdv_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         areq_ff.start <= 1'b0;
      end else begin
         areq_ff.start <= 1'b0;
         rdv_ff        <= mem_re;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (rdv_ff) begin
            for (int c = 0; c < 3; c++) cnt_ff[c] <= cnt_ff[c] + 7'(hit[c]);
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_cmd;
                  pix_ff   <= {req_red_in, req_green_in, req_blue_in};
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               in_row_ff <= prep_row;
               in_col_ff <= prep_col;
               if (prep_clr) begin
                  out_row_ff <= '0;
                  out_col_ff <= '0;
               end
               if (cmd_ff == CMD_PIXEL && prep_row < h_eff) begin
                  areq_ff.start <= 1'b1;
                  areq_ff.row   <= prep_row[11:0];
                  areq_ff.col   <= prep_col;
                  areq_ff.width <= w_eff;
                  state_ff      <= S_WADDR;
               end else begin
                  state_ff <= S_CHK;
               end
            end
            S_WADDR: begin
               if (addr_done) begin
                  if (in_col_inc >= w_eff) begin
                     in_col_ff <= '0;
                     in_row_ff <= in_row_ff + ROW_W'(1);
                  end else begin
                     in_col_ff <= in_col_inc[COL_W-1:0];
                  end
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               out_col_ff  <= chk_col;
               need_row_ff <= chk_need_row;
               need_col_ff <= chk_need_col;
               y1_ff       <= chk_y1;
               x1_ff       <= chk_x1;
               state_ff    <= S_MUL;
            end
            S_MUL: begin
               inpos_ff   <= 24'(24'(in_row_ff) * 24'(w_eff) + 24'(in_col_ff));
               needpos_ff <= 24'(24'(need_row_ff) * 24'(w_eff) + 24'(need_col_ff));
               state_ff   <= S_CMP;
            end
            S_CMP: begin
               if (in_row_ff >= h_eff || inpos_ff > needpos_ff) begin
                  for (int c = 0; c < 3; c++) begin
                     rank_ff[c] <= win_rank;
                     cnt_ff[c]  <= '0;
                     pre_ff[c]  <= '0;
                  end
                  bit_ff        <= 3'd7;
                  y_ff          <= y1_ff;
                  areq_ff.start <= 1'b1;
                  areq_ff.row   <= y1_ff;
                  areq_ff.col   <= x1_ff;
                  areq_ff.width <= w_eff;
                  state_ff      <= S_ROWSTART;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_ROWSTART: begin
               if (addr_done) begin
                  rd_addr_ff <= addr_out;
                  x_ff       <= x1_ff;
                  state_ff   <= S_SWEEP;
               end
            end
            S_SWEEP: begin
               rd_addr_ff <= (rd_addr_ff == ADDR_W'(LINE_DEPTH - 1)) ? '0
                                                                   : rd_addr_ff + ADDR_W'(1);
               if (x_ff == need_col_ff) begin
                  if (y_ff == need_row_ff) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     y_ff          <= y_ff + 12'd1;
                     areq_ff.start <= 1'b1;
                     areq_ff.row   <= y_ff + 12'd1;
                     areq_ff.col   <= x1_ff;
                     areq_ff.width <= w_eff;
                     state_ff      <= S_ROWSTART;
                  end
               end else begin
                  x_ff <= x_ff + COL_W'(1);
               end
            end
            S_DRAIN: begin
               // last read word is counted at this edge
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               for (int c = 0; c < 3; c++) begin
                  if ({1'b0, rank_ff[c]} >= cnt_ff[c]) begin
                     pre_ff[c][bit_ff] <= 1'b1;
                     rank_ff[c]        <= rank_ff[c] - cnt_ff[c][5:0];
                  end
                  cnt_ff[c] <= '0;
               end
               if (bit_ff == 3'd0) begin
                  state_ff <= S_OUT;
               end else begin
                  bit_ff        <= bit_ff - 3'd1;
                  y_ff          <= y1_ff;
                  areq_ff.start <= 1'b1;
                  areq_ff.row   <= y1_ff;
                  areq_ff.col   <= x1_ff;
                  areq_ff.width <= w_eff;
                  state_ff      <= S_ROWSTART;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_r_ff     <= pre_ff[0];
                  rsp_g_ff     <= pre_ff[1];
                  rsp_b_ff     <= pre_ff[2];
                  if (out_row_inc >= h_eff) begin
                     fe_ff      <= 1'b1;
                     in_col_ff  <= '0;
                     in_row_ff  <= '0;
                     out_col_ff <= '0;
                     out_row_ff <= '0;
                  end else begin
                     fe_ff      <= 1'b0;
                     out_col_ff <= out_wrap ? '0 : out_col_inc[COL_W-1:0];
                     out_row_ff <= out_row_inc;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_r_ff;
   assign rsp_green_out = rsp_g_ff;
   assign rsp_blue_out  = rsp_b_ff;
   assign rsp_frame_end = fe_ff;

   `RMWF_ASSERT_IMPLY(a_no_rw_clash, clock, reset, mem_we, !mem_re, "memory write and read together")
   `RMWF_ASSERT_IMPLY(a_addr_expected, clock, reset, addr_done, (state_ff == S_WADDR) || (state_ff == S_ROWSTART), "stray address")
   `RMWF_ASSERT_IMPLY(a_pass_drained, clock, reset, state_ff == S_DECIDE, !rdv_ff, "read in flight")
   `RMWF_ASSERT_NEXT(a_write_advances, clock, reset, mem_we, (in_col_ff != $past(in_col_ff)) || (in_row_ff != $past(in_row_ff)), "input stuck")
endmodule

### dv/rgb_median_window_filter_top_tb.sv
// Self-checking testbench for the per-channel RGB median window filter.
module rgb_median_window_filter_top_tb
   import rmwf_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // Allowance for a full 9x9 median plus set-up, used before a CSR write
   // and at the end of the run (a drain tick may still be in the engine).
   localparam int SETTLE_CYCLES = 1100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_PIXEL;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        rsp_frame_end;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_WIDTH;
   logic [12:0] csr_wdata = '0;

   rgb_median_window_filter_top dut (.*);

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } pixel_result_type;

   // One row of the directed table; typed results only where obvious.
   typedef struct {
      logic             cmd;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      bit               typed;
      bit               yields;
      pixel_result_type want;
   } directed_row_type;

   pixel_result_type pending_pixels[$];
   int            errors = 0;
   int            frames_done = 0;
   int            hold_len = 0;
   int            burst_left = 1;
   bit            valid_up = 1'b0;

   // Shadow of the CSRs and counters of the filter.
   int unsigned   shadow_width = 1024, shadow_height = 1024, shadow_level = 8;
   int unsigned   col_in = 0, row_in = 0, col_out = 0, row_out = 0;
   logic [23:0]   orig_pixels[LINE_DEPTH];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Fixed ceiling on the run, far above the slowest legal run.
   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int unsigned clipped_width();
      int unsigned w = shadow_width & 11'h7ff;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned clipped_height();
      int unsigned h = shadow_height & 13'h1fff;
      if (h == 0) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   function automatic int unsigned clipped_radius();
      int unsigned r = (shadow_level & 4'hf) >> 1;
      if (r > MAX_RADIUS) r = MAX_RADIUS;
      return r;
   endfunction

   function automatic logic [7:0] lower_median(ref logic [7:0] vals[$]);
      vals.sort();
      return vals[(vals.size() - 1) >> 1];
   endfunction

   // Advances the shadow filter by one word; returns 1 when a pixel comes out.
   function automatic bit median_step(input logic cmd, input logic [7:0] red,
                                      input logic [7:0] green, input logic [7:0] blue,
                                      output pixel_result_type res);
      int unsigned w = clipped_width();
      int unsigned h = clipped_height();
      int unsigned r = clipped_radius();
      int unsigned last_row, last_col, y1, x1;
      logic [23:0] p;
      logic [7:0]  reds[$], greens[$], blues[$];
      res = '{default: '0};
      if (row_out >= h) begin
         col_in = 0; row_in = 0; col_out = 0; row_out = 0;
      end
      if (col_in >= w) col_in = 0;
      if (cmd == CMD_PIXEL && row_in < h) begin
         orig_pixels[(row_in * w + col_in) % LINE_DEPTH] = {red, green, blue};
         col_in++;
         if (col_in >= w) begin
            col_in = 0;
            row_in++;
         end
      end
      if (col_out >= w) col_out = 0;
      last_row = (row_out + r > h - 1) ? h - 1 : row_out + r;
      last_col = (col_out + r > w - 1) ? w - 1 : col_out + r;
      if (!(row_in >= h || row_in * w + col_in > last_row * w + last_col)) return 1'b0;
      y1 = (row_out > r) ? row_out - r : 0;
      x1 = (col_out > r) ? col_out - r : 0;
      for (int unsigned y = y1; y <= last_row; y++) begin
         for (int unsigned x = x1; x <= last_col; x++) begin
            p = orig_pixels[(y * w + x) % LINE_DEPTH];
            reds.push_back(p[23:16]);
            greens.push_back(p[15:8]);
            blues.push_back(p[7:0]);
         end
      end
      if (reds.size() != 0) begin
         res.red   = lower_median(reds);
         res.green = lower_median(greens);
         res.blue  = lower_median(blues);
      end
      col_out++;
      if (col_out >= w) begin
         col_out = 0;
         row_out++;
      end
      if (row_out >= h) begin
         res.frame_end = 1'b1;
         col_in = 0; row_in = 0; col_out = 0; row_out = 0;
         frames_done++;
      end
      return 1'b1;
   endfunction

   task automatic drop_valid();
      if (valid_up) req_valid <= 1'b0;
      valid_up = 1'b0;
   endtask

   // Offers one word, waits for it to go in, then maybe ends the burst.
   task automatic push_word(input logic cmd, input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, output bit yields,
                            output pixel_result_type res);
      int gap;
      req_valid    <= 1'b1;
      valid_up     = 1'b1;
      req_cmd      <= cmd;
      req_red_in   <= red;
      req_green_in <= green;
      req_blue_in  <= blue;
      do @(posedge clock); while (!req_ready);
      yields = median_step(cmd, red, green, blue, res);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_word(input logic cmd, input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
      bit               yields;
      pixel_result_type res;
      push_word(cmd, red, green, blue, yields, res);
      if (yields) pending_pixels.push_back(res);
   endtask

   task automatic wait_drained();
      drop_valid();
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // CSR writes only with the filter idle.
   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned lvl);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= 13'(w);
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= 13'(h);
      @(posedge clock);
      csr_index <= CSR_LEVEL;
      csr_wdata <= 13'(lvl);
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_width  = w & 11'h7ff;
      shadow_height = h & 13'h1fff;
      shadow_level  = lvl & 4'hf;
   endtask

   function automatic logic [7:0] colour_value();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // Streams one whole region, with stray drain ticks when noisy, then flushes it.
   task automatic run_region(input bit noisy);
      int unsigned total = clipped_width() * clipped_height();
      int          start = frames_done;
      for (int unsigned i = 0; i < total; i++) begin
         if (noisy && $urandom_range(0, 9) == 0)
            send_word(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
         send_word(CMD_PIXEL, colour_value(), colour_value(), colour_value());
      end
      // pixels beyond the region are dropped while it drains
      repeat ($urandom_range(0, 2))
         if (frames_done == start)
            send_word(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
      while (frames_done == start)
         send_word(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Receiver: long hold when asked, otherwise calm or choppy spells at random.
   initial begin
      int spell;
      bit choppy;
      spell  = 0;
      choppy = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            hold_len--;
            rsp_ready <= 1'b0;
         end else begin
            if (spell == 0) begin
               spell  = $urandom_range(50, 400);
               choppy = $urandom_range(0, 1);
            end
            spell--;
            rsp_ready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
         end
      end
   end

   // Result checker: each word against the oldest outstanding prediction.
   initial begin
      pixel_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $display("unexpected result word at %0t", $realtime);
               errors++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_red_out !== want.red) report("red", rsp_red_out, want.red);
               if (rsp_green_out !== want.green) report("green", rsp_green_out, want.green);
               if (rsp_blue_out !== want.blue) report("blue", rsp_blue_out, want.blue);
               if (rsp_frame_end !== want.frame_end)
                  report("frame_end", rsp_frame_end, want.frame_end);
            end
         end
      end
   end

   // Directed words for a 3x1 region with radius 0: each pixel comes straight back.
   directed_row_type directed_words[] = '{
      '{CMD_PIXEL, 8'h00, 8'h00, 8'h00, 1, 1, '{8'h00, 8'h00, 8'h00, 1'b0}},
      '{CMD_PIXEL, 8'hff, 8'hff, 8'hff, 1, 1, '{8'hff, 8'hff, 8'hff, 1'b0}},
      '{CMD_PIXEL, 8'h5a, 8'ha5, 8'h3c, 1, 1, '{8'h5a, 8'ha5, 8'h3c, 1'b1}},
      '{CMD_DRAIN, 8'hff, 8'h00, 8'hff, 1, 0, '{8'h00, 8'h00, 8'h00, 1'b0}},
      '{CMD_PIXEL, 8'h01, 8'h02, 8'h03, 1, 1, '{8'h01, 8'h02, 8'h03, 1'b0}},
      '{CMD_PIXEL, 8'h80, 8'h40, 8'h20, 1, 1, '{8'h80, 8'h40, 8'h20, 1'b0}},
      '{CMD_PIXEL, 8'h7f, 8'hbf, 8'hdf, 1, 1, '{8'h7f, 8'hbf, 8'hdf, 1'b1}},
      '{CMD_DRAIN, 8'h00, 8'hff, 8'h00, 1, 0, '{8'h00, 8'h00, 8'h00, 1'b0}},
      '{CMD_PIXEL, 8'hc3, 8'h3c, 8'h96, 0, 0, '{8'h00, 8'h00, 8'h00, 1'b0}},
      '{CMD_PIXEL, 8'h69, 8'he1, 8'h1e, 0, 0, '{8'h00, 8'h00, 8'h00, 1'b0}},
      '{CMD_PIXEL, 8'h0f, 8'hf0, 8'haa, 0, 0, '{8'h00, 8'h00, 8'h00, 1'b0}}
   };

   initial begin
      bit               yields;
      pixel_result_type res;
      int               random_words;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      configure(3, 1, 0);
      foreach (directed_words[i]) begin
         push_word(directed_words[i].cmd, directed_words[i].red, directed_words[i].green,
                   directed_words[i].blue, yields, res);
         if (directed_words[i].typed) begin
            if (yields != directed_words[i].yields)
               report("word yields result", yields, directed_words[i].yields);
            if (directed_words[i].yields) pending_pixels.push_back(directed_words[i].want);
         end else if (yields) begin
            pending_pixels.push_back(res);
         end
      end

      // small regions at radii 4 and 1, incl. zero height and level above 8
      configure(5, 5, 8);
      run_region(1'b0);
      configure(4, 0, 15);
      run_region(1'b1);
      configure(1, 6, 3);
      run_region(1'b0);
      // full 9x9 window in the middle of the region
      configure(10, 10, 8);
      run_region(1'b1);

      // one long receiver hold while words keep coming, so the input backs up
      configure(6, 4, 4);
      hold_len = 3000;
      run_region(1'b0);

      // width above the maximum: part of one row, window clipped vertically
      configure(2047, 1, 15);
      repeat (40) send_word(CMD_PIXEL, colour_value(), colour_value(), colour_value());
      // zero width, height above the maximum: part of a single column
      configure(0, 8191, 1);
      repeat (30) send_word(CMD_PIXEL, colour_value(), colour_value(), colour_value());
      // a one-pixel region restarts the open frame
      configure(1, 1, 0);
      run_region(1'b0);

      // random regions; mostly small so the bit-serial engine stays quick
      random_words = 0;
      while (random_words < 450) begin
         configure($urandom_range(1, 12), $urandom_range(0, 8),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8));
         random_words += clipped_width() * clipped_height();
         run_region($urandom_range(0, 1));
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
